@@ rtl/lppd_pkg.sv @@
// package with shared widths and header position codes for the packet deframer
`timescale 1ns / 1ps

package lppd_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int POS_W       = 3;
  // payload_byte, packet_type, payload_length packed from the lowest bit up
  localparam int OUT_TDATA_W = BYTE_W + WORD_W + WORD_W;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // header position codes
  localparam pos_t POS_LEN_LO  = 3'd0;
  localparam pos_t POS_LEN_HI  = 3'd1;
  localparam pos_t POS_TYPE_LO = 3'd2;
  localparam pos_t POS_TYPE_HI = 3'd3;
  localparam pos_t POS_PAYLOAD = 3'd4;

endpackage

@@ rtl/length_prefixed_packet_deframer.sv @@
// top level: byte stream to length-prefixed packet deframer
`timescale 1ns / 1ps

// usage
//   in_*  : one received stream byte per transaction (in_tdata[7:0])
//   out_* : one transaction per payload byte, tagged with the packet type and
//           the payload size from the header; out_tlast marks the final byte
//           of a packet, out_tuser marks a zero-length packet (one transaction
//           with byte zero and tlast set)
//   each packet opens with a four-byte header: size low, size high, type low,
//   type high; header bytes produce no output transaction, but for the zero-length marker on type high
// output: a payload byte appears on out_* in the cycle after its input
//   transaction; the header state and the output register update together
// throughput: one byte per cycle while out_tready stays high, set by the single output register
//   which is refilled in the same cycle it is drained
// reset: rst_n low clears the header position and the counters, drops
//   out_tvalid; the block then waits for header byte zero
// stall: while out_tvalid is high and out_tready low, in_tready is low and the
//   held output transaction stays unchanged; nothing is dropped
module length_prefixed_packet_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lppd_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] payload_byte, [23:8] packet_type, [39:24] payload_length
  output logic [lppd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,  // is_last
  output logic                             out_tuser   // [0] is_empty
);

  import lppd_pkg::*;

  // header and count state
  pos_t  pos_r,  pos_nxt;
  word_t len_r,  len_nxt;
  word_t type_r, type_nxt;
  word_t rem_r,  rem_nxt;

  // output register
  logic  out_valid_r;
  byte_t out_byte_r,  res_byte;
  word_t out_type_r,  res_type;
  word_t out_len_r,   res_len;
  logic  out_last_r,  res_last;
  logic  out_empty_r, res_empty;
  logic  res_valid;

  logic  in_xfer;

  // the output register can take a new result when empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // per-byte decode: header collection and payload counting
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res_byte  = in_tdata;
    res_type  = type_r;
    res_len   = len_r;
    res_last  = 1'b0;
    res_empty = 1'b0;
    case (pos_r)
      POS_PAYLOAD: begin
        if (rem_r != '0) begin
          // payload byte, cut-through
          rem_nxt   = rem_r - word_t'(1);
          res_valid = 1'b1;
          res_last  = (rem_r == word_t'(1));
          if (res_last) begin
            pos_nxt = POS_LEN_LO;
          end
        end else begin
          len_nxt = {8'h00, in_tdata};
          pos_nxt = POS_LEN_HI;
        end
      end
      POS_LEN_HI: begin
        len_nxt = {in_tdata, len_r[7:0]};
        pos_nxt = POS_TYPE_LO;
      end
      POS_TYPE_LO: begin
        type_nxt = {8'h00, in_tdata};
        pos_nxt  = POS_TYPE_HI;
      end
      POS_TYPE_HI: begin
        type_nxt = {in_tdata, type_r[7:0]};
        if (len_r == '0) begin
          // zero-length packet: one empty marker
          pos_nxt   = POS_LEN_LO;
          res_valid = 1'b1;
          res_byte  = '0;
          res_type  = {in_tdata, type_r[7:0]};
          res_last  = 1'b1;
          res_empty = 1'b1;
        end else begin
          rem_nxt = len_r;
          pos_nxt = POS_PAYLOAD;
        end
      end
      default: begin
        // header byte zero, also any unused position code
        len_nxt = {8'h00, in_tdata};
        pos_nxt = POS_LEN_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_LEN_LO;
      len_r       <= '0;
      type_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        pos_r       <= pos_nxt;
        len_r       <= len_nxt;
        type_r      <= type_nxt;
        rem_r       <= rem_nxt;
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the output register, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_byte_r  <= res_byte;
      out_type_r  <= res_type;
      out_len_r   <= res_len;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_type_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

@@ rtl/lppd_checker.sv @@
// port-level checker for the packet deframer, with its bind
`timescale 1ns / 1ps

module lppd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lppd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic                             out_tuser
);

  import lppd_pkg::*;

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // a stalled output blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // an empty packet marker is always the last of its packet
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("empty marker without tlast");

  // an empty marker carries byte zero and size zero
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[BYTE_W-1:0] == '0
      && out_tdata[OUT_TDATA_W-1:BYTE_W+WORD_W] == '0)
    else $error("empty marker with nonzero byte or size");

  // reset drops the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

@@ tb/sv/tb.sv @@
// self-checking testbench for the length-prefixed packet deframer
`timescale 1ns / 1ps

module tb;
  import lppd_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 1000000;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 200;
  // drain wait after the last expected transaction, as a margin
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 280;
  // payload bytes sent into the open maximum-size packet
  localparam int MAX_TAIL     = 64;

  // one result transaction as seen on out_*
  typedef struct packed {
    byte_t data;
    word_t ptype;
    word_t plen;
    logic  last;
    logic  empty;
  } beat_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [BYTE_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  // deframer state as predicted by the testbench
  pos_t  hdr_pos;
  word_t hdr_len;
  word_t hdr_type;
  word_t bytes_left;
  beat_t expected_beats[$];

  int error_count;
  int cycle_count = 0;
  int bytes_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen = 0;
  int hold_left = 0;

  length_prefixed_packet_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // predictor: one accepted stream byte, at most one expected transaction
  function automatic void deframe_byte(input byte_t b);
    beat_t beat;
    beat = '0;
    if (hdr_pos == POS_PAYLOAD && bytes_left != 0) begin
      bytes_left = bytes_left - 1'b1;
      beat.data  = b;
      beat.ptype = hdr_type;
      beat.plen  = hdr_len;
      beat.last  = (bytes_left == 0);
      beat.empty = 1'b0;
      expected_beats.push_back(beat);
      if (bytes_left == 0) hdr_pos = POS_LEN_LO;
      return;
    end
    case (hdr_pos)
      POS_LEN_HI: begin
        hdr_len[15:8] = b;
        hdr_pos = POS_TYPE_LO;
      end
      POS_TYPE_LO: begin
        hdr_type = {8'h00, b};
        hdr_pos = POS_TYPE_HI;
      end
      POS_TYPE_HI: begin
        hdr_type[15:8] = b;
        if (hdr_len == 0) begin
          // zero-length packet: one transaction flagged empty and last
          beat.data  = '0;
          beat.ptype = hdr_type;
          beat.plen  = hdr_len;
          beat.last  = 1'b1;
          beat.empty = 1'b1;
          expected_beats.push_back(beat);
          hdr_pos = POS_LEN_LO;
        end else begin
          bytes_left = hdr_len;
          hdr_pos = POS_PAYLOAD;
        end
      end
      default: begin
        // header byte zero, also taken for any unused position code
        hdr_len = {8'h00, b};
        hdr_pos = POS_LEN_HI;
      end
    endcase
  endfunction

  // result side: compare every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        $display("unexpected transaction at cycle %0d: tdata 0x%0h", cycle_count, out_tdata);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata[7:0] !== want.data)
          report_mismatch("payload_byte", out_tdata[7:0], want.data);
        if (out_tdata[23:8] !== want.ptype)
          report_mismatch("packet_type", out_tdata[23:8], want.ptype);
        if (out_tdata[39:24] !== want.plen)
          report_mismatch("payload_length", out_tdata[39:24], want.plen);
        if (out_tlast !== want.last)
          report_mismatch("is_last", out_tlast, want.last);
        if (out_tuser !== want.empty)
          report_mismatch("is_empty", out_tuser, want.empty);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input word_t len, input word_t ptype);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(ptype[7:0]);
    send_byte(ptype[15:8]);
  endtask

  task automatic send_random_packet(input int len);
    send_header(len[15:0], word_t'($urandom_range(65535)));
    for (int i = 0; i < len; i++) send_byte(byte_t'($urandom_range(255)));
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // empty packets, one-byte and three-byte packets, byte and type extremes
  task automatic test_directed();
    set_idling(0, 0);
    send_header(16'h0000, 16'hFFFF);
    send_header(16'h0001, 16'h0000);
    send_byte(8'hFF);
    send_header(16'h0003, 16'h8001);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_header(16'h0000, 16'h0000);
  endtask

  // size 256 carries the count across its low byte; the largest size drives
  // every size bit high and is left open, so this test runs last
  task automatic test_max_size();
    set_idling(0, 0);
    send_header(16'h0100, 16'hC3C3);
    for (int i = 0; i < 256; i++) send_byte(byte_t'(i));
    send_header(16'hFFFF, 16'h1234);
    for (int i = 0; i < MAX_TAIL; i++) send_byte(byte_t'($urandom_range(255)));
  endtask

  // well-formed packets with random sizes and contents
  task automatic test_random_phase(input int send_pct, input int stall_pct);
    int start;
    int pick;
    int len;
    set_idling(send_pct, stall_pct);
    start = bytes_sent;
    while (bytes_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 0;
      else if (pick < 85) len = $urandom_range(8, 1);
      else if (pick < 98) len = $urandom_range(40, 9);
      else                len = $urandom_range(300, 250);
      send_random_packet(len);
    end
  endtask

  // receiver holds off long enough that the input side stalls
  task automatic test_backpressure_hold();
    set_idling(0, 0);
    hold_req = hold_req + 1;
    send_random_packet(40);
    send_random_packet(0);
    send_random_packet(5);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    hdr_pos        = POS_LEN_LO;
    hdr_len        = '0;
    hdr_type       = '0;
    bytes_left     = '0;
    error_count    = 0;
    bytes_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(0, 0);
    test_backpressure_hold();
    test_random_phase(80, 0);
    test_random_phase(0, 80);
    test_random_phase(11, 11);
    test_max_size();
    drain();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lppd_pkg.sv
rtl/length_prefixed_packet_deframer.sv
rtl/lppd_checker.sv
tb/sv/tb.sv
